[rtl/core/i2cmts_pkg.sv]
// Shared types, constants and status codes of the I2C master transfer sequencer.
package i2cmts_pkg;

    // Transmit buffer depth and derived widths
    localparam int MAX_LEN = 256;
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int WIDE_W  = 13;
    localparam int POS_W   = 11;
    localparam logic [8:0] LEN_CAP = (MAX_LEN < 511) ? 9'(MAX_LEN) : 9'd511;

    // Request kinds
    localparam logic [1:0] REQ_EVENT = 2'd0;
    localparam logic [1:0] REQ_BEGIN = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;

    // Controller status codes
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RSTART    = 8'h10;
    localparam logic [7:0] ST_WADDR_ACK = 8'h18;
    localparam logic [7:0] ST_DATA_TX   = 8'h28;
    localparam logic [7:0] ST_RADDR_ACK = 8'h40;
    localparam logic [7:0] ST_DATA_RX   = 8'h50;
    localparam logic [7:0] ST_LAST_RX   = 8'h58;

    // Message phases
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_ADDR_W = 3'd1;
    localparam logic [2:0] PH_ADDR_R = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_RECV   = 3'd4;

    // Acknowledge control and completion codes
    localparam logic [1:0] ACK_KEEP  = 2'd0;
    localparam logic [1:0] ACK_SET   = 2'd1;
    localparam logic [1:0] ACK_CLEAR = 2'd2;
    localparam logic [1:0] CMP_NONE  = 2'd0;
    localparam logic [1:0] CMP_PASS  = 2'd1;
    localparam logic [1:0] CMP_FAIL  = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] status_code;
        logic [7:0] rx_byte;
        logic [7:0] slave_address;
        logic [7:0] mem_addr_high;
        logic [7:0] mem_addr_low;
        logic [8:0] msg_length;
        logic [7:0] load_index;
        logic [7:0] load_byte;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_value;
        logic       set_start;
        logic       clear_start;
        logic       set_stop;
        logic [1:0] ack_control;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic [7:0] rx_position;
        logic [1:0] completion;
        logic       rejected;
        logic       bus_free;
    } result_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } buf_wr_t;

endpackage

[rtl/core/i2cmts_txbuf.sv]
// Transmit buffer memory with registered read and write-to-read forwarding.
module i2cmts_txbuf
    import i2cmts_pkg::*;
(
    input  logic             clk,
    input  buf_wr_t          wr,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [MAX_LEN];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        // forward a same-cycle load so the prefetched byte is never stale
        if (wr.en && (wr.addr == rd_addr))
        begin
            rd_data_reg <= wr.data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/i2cmts_seq.sv]
// Message state and per-word decode of begin, load and status event requests.
module i2cmts_seq
    import i2cmts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  item_t            item,
    input  logic [7:0]       rd_data,
    output result_t          result,
    output buf_wr_t          wr,
    output logic [IDX_W-1:0] rd_addr
);

    logic [2:0]              phase_reg, phase_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic                    active_reg, active_next;
    logic [7:0]              slave_reg, slave_next;
    logic [7:0]              addr_hi_reg, addr_hi_next;
    logic [7:0]              addr_lo_reg, addr_lo_next;
    logic [8:0]              len_reg, len_next;

    logic signed [POS_W-1:0] len_s;
    logic signed [POS_W-1:0] pos_inc;
    logic [POS_W-1:0]        pos_ahead;
    logic [WIDE_W-1:0]       rd_wide;
    logic [WIDE_W-1:0]       wr_wide;

    assign len_s   = $signed({{(POS_W-9){1'b0}}, len_reg});
    assign pos_inc = pos_reg + POS_W'(1);
    assign wr_wide = {{(WIDE_W-8){1'b0}}, item.load_index};

    always_comb
    begin
        result       = '0;
        wr.en        = 1'b0;
        wr.addr      = wr_wide[IDX_W-1:0];
        wr.data      = item.load_byte;
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        active_next  = active_reg;
        slave_next   = slave_reg;
        addr_hi_next = addr_hi_reg;
        addr_lo_next = addr_lo_reg;
        len_next     = len_reg;

        unique case (item.req_type)
            REQ_EVENT:
            begin
                if (active_reg)
                begin
                    unique case (phase_reg)
                        PH_START:
                        begin
                            result.clear_start = 1'b1;
                            if ((item.status_code == ST_START) ||
                                (item.status_code == ST_RSTART))
                            begin
                                result.tx_valid = 1'b1;
                                result.tx_value = slave_reg;
                                if (slave_reg[0])
                                begin
                                    phase_next = PH_ADDR_R;
                                    pos_next   = '0;
                                end
                                else
                                begin
                                    phase_next = PH_ADDR_W;
                                    pos_next   = -POS_W'(2);
                                end
                            end
                            else
                            begin
                                result.set_stop    = 1'b1;
                                result.ack_control = ACK_CLEAR;
                                result.completion  = CMP_FAIL;
                                phase_next         = PH_START;
                                active_next        = 1'b0;
                            end
                        end
                        PH_ADDR_W:
                        begin
                            if (item.status_code == ST_WADDR_ACK)
                            begin
                                result.tx_valid = 1'b1;
                                result.tx_value = addr_hi_reg;
                                phase_next      = PH_DATA;
                            end
                            else
                            begin
                                result.set_stop    = 1'b1;
                                result.ack_control = ACK_CLEAR;
                                result.completion  = CMP_FAIL;
                                phase_next         = PH_START;
                                active_next        = 1'b0;
                            end
                        end
                        PH_ADDR_R:
                        begin
                            if (item.status_code == ST_RADDR_ACK)
                            begin
                                phase_next = PH_RECV;
                                if (len_reg > 9'd1)
                                begin
                                    result.ack_control = ACK_SET;
                                end
                            end
                            else
                            begin
                                result.set_stop    = 1'b1;
                                result.ack_control = ACK_CLEAR;
                                result.completion  = CMP_FAIL;
                                phase_next         = PH_START;
                                active_next        = 1'b0;
                            end
                        end
                        PH_RECV:
                        begin
                            if ((item.status_code == ST_DATA_RX) ||
                                (item.status_code == ST_LAST_RX))
                            begin
                                result.rx_valid    = 1'b1;
                                result.rx_data     = item.rx_byte;
                                result.rx_position = pos_reg[7:0];
                                pos_next           = pos_inc;
                                if (pos_inc >= len_s)
                                begin
                                    result.set_stop    = 1'b1;
                                    result.ack_control = ACK_CLEAR;
                                    result.completion  = CMP_PASS;
                                    phase_next         = PH_START;
                                    active_next        = 1'b0;
                                end
                                else if ((pos_inc + POS_W'(1)) == len_s)
                                begin
                                    // withhold acknowledge on the last byte
                                    result.ack_control = ACK_CLEAR;
                                end
                            end
                            else
                            begin
                                result.set_stop    = 1'b1;
                                result.ack_control = ACK_CLEAR;
                                result.completion  = CMP_FAIL;
                                phase_next         = PH_START;
                                active_next        = 1'b0;
                            end
                        end
                        PH_DATA:
                        begin
                            if (item.status_code == ST_DATA_TX)
                            begin
                                pos_next = pos_inc;
                                if (pos_inc < 0)
                                begin
                                    result.tx_valid = 1'b1;
                                    result.tx_value = addr_lo_reg;
                                end
                                else if (pos_inc < len_s)
                                begin
                                    result.tx_valid = 1'b1;
                                    result.tx_value = rd_data;
                                end
                                else
                                begin
                                    result.set_stop    = 1'b1;
                                    result.ack_control = ACK_CLEAR;
                                    result.completion  = CMP_PASS;
                                    phase_next         = PH_START;
                                    active_next        = 1'b0;
                                end
                            end
                            else
                            begin
                                result.set_stop    = 1'b1;
                                result.ack_control = ACK_CLEAR;
                                result.completion  = CMP_FAIL;
                                phase_next         = PH_START;
                                active_next        = 1'b0;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_START;
                        end
                    endcase
                end
            end
            REQ_BEGIN:
            begin
                if (active_reg)
                begin
                    result.rejected = 1'b1;
                end
                else
                begin
                    slave_next       = item.slave_address;
                    addr_hi_next     = item.mem_addr_high;
                    addr_lo_next     = item.mem_addr_low;
                    len_next         = (item.msg_length > LEN_CAP) ? LEN_CAP : item.msg_length;
                    phase_next       = PH_START;
                    pos_next         = -POS_W'(2);
                    active_next      = 1'b1;
                    result.set_start = 1'b1;
                end
            end
            REQ_LOAD:
            begin
                wr.en = fire && (wr_wide < WIDE_W'(MAX_LEN));
            end
            default:
            begin
                result = '0;
            end
        endcase

        result.bus_free = !active_next;
    end

    // prefetch the buffer byte the next data event would send
    assign pos_ahead = POS_W'((fire ? pos_next : pos_reg) + POS_W'(1));
    assign rd_wide   = {{(WIDE_W-POS_W){1'b0}}, pos_ahead};
    assign rd_addr   = rd_wide[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            pos_reg     <= -POS_W'(2);
            active_reg  <= 1'b0;
            slave_reg   <= '0;
            addr_hi_reg <= '0;
            addr_lo_reg <= '0;
            len_reg     <= 9'd1;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            active_reg  <= active_next;
            slave_reg   <= slave_next;
            addr_hi_reg <= addr_hi_next;
            addr_lo_reg <= addr_lo_next;
            len_reg     <= len_next;
        end
    end

endmodule

[rtl/core/i2c_master_transfer_sequencer_top.sv]
// I2C master transfer sequencer: one result word per request word. A word is taken into an
// input register, decoded against the message state and its result lands in an output
// register, so a result word is offered once its request word has passed both registers,
// and a new word is taken every cycle while the output side keeps up. The transmit buffer
// (MAX_LEN bytes) is read ahead at the position following the current one, which is what
// lets a data event use a synchronous memory without a stall. Loads may be issued at any
// time, also during a message; bytes sent must have been loaded beforehand.
module i2c_master_transfer_sequencer_top
    import i2cmts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // status_code, rx_byte, slave_address, mem_addr_high, mem_addr_low, msg_length,
    // load_index, load_byte, zero fill
    input  logic [71:0] s_tdata,
    // req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_value, set_start, clear_start, set_stop, ack_control, rx_data, rx_position,
    // completion, rejected, bus_free, zero fill
    output logic [39:0] m_tdata,
    // tx_valid, rx_valid
    output logic [1:0]  m_tuser
);

    logic             in_valid_reg;
    item_t            in_item_reg;
    logic             out_valid_reg;
    result_t          out_res_reg;
    logic             fire;
    result_t          result;
    buf_wr_t          wr;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    item_t            s_item;

    assign s_item.req_type      = s_tuser;
    assign s_item.status_code   = s_tdata[7:0];
    assign s_item.rx_byte       = s_tdata[15:8];
    assign s_item.slave_address = s_tdata[23:16];
    assign s_item.mem_addr_high = s_tdata[31:24];
    assign s_item.mem_addr_low  = s_tdata[39:32];
    assign s_item.msg_length    = s_tdata[48:40];
    assign s_item.load_index    = s_tdata[56:49];
    assign s_item.load_byte     = s_tdata[64:57];

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= s_item;
        end
        if (fire)
        begin
            out_res_reg <= result;
        end
    end

    i2cmts_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (in_item_reg),
        .rd_data (rd_data),
        .result  (result),
        .wr      (wr),
        .rd_addr (rd_addr)
    );

    i2cmts_txbuf u_txbuf (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_res_reg.bus_free, out_res_reg.rejected,
                       out_res_reg.completion, out_res_reg.rx_position, out_res_reg.rx_data,
                       out_res_reg.ack_control, out_res_reg.set_stop, out_res_reg.clear_start,
                       out_res_reg.set_start, out_res_reg.tx_value};
    assign m_tuser  = {out_res_reg.rx_valid, out_res_reg.tx_valid};

endmodule

[rtl/core/i2cmts_checker.sv]
// Port-level checks of the I2C master transfer sequencer, bound to the top level.
module i2cmts_checker
    import i2cmts_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a refused begin leaves the running message in place
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[31] |-> !m_tdata[32] && !m_tdata[8])
        else $error("rejected begin with bus free or start requested");

    // every completion ends the message with a stop
    a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[30:29] != CMP_NONE) |-> m_tdata[32] && m_tdata[10]
            && (m_tdata[12:11] == ACK_CLEAR))
        else $error("completion without stop and free bus");

    // a word never both sends and delivers a byte
    a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("transmit and receive in one result word");

endmodule

bind i2c_master_transfer_sequencer_top i2cmts_checker u_checker (.*);

[sim/tb_i2c_master_transfer_sequencer_top.sv]
// Self-checking testbench for the I2C master transfer sequencer.
module tb_i2c_master_transfer_sequencer_top;
    import i2cmts_pkg::*;

    localparam int RANDOM_ITEMS   = 750;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct {
        item_t word;
        bit    drain;
    } queued_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    queued_word_t pending_words[$];
    queued_word_t head_word;
    result_t      expected_results[$];
    item_t        offered_word;
    bit           loaded[MAX_LEN];
    bit           drain_next;
    int           noise_pct;
    int           n_items;
    int           n_total;
    int           words_sent;
    int           results_taken;
    int           mismatches;
    int           hold_left;
    bit           held;
    int           quiet_cycles;

    // Predictor state
    logic [2:0] msg_phase = PH_START;
    int         msg_pos = -2;
    bit         msg_active = 1'b0;
    logic [7:0] msg_slave = '0;
    logic [7:0] msg_addr_hi = '0;
    logic [7:0] msg_addr_lo = '0;
    int         msg_len = 1;
    logic [7:0] tx_mem[MAX_LEN];

    always #10 clk = ~clk;

    i2c_master_transfer_sequencer_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic result_t predict_sequencer_word(input item_t w);
        result_t r;
        bit      pass;
        bit      fail;
        r = '0;
        pass = 1'b0;
        fail = 1'b0;
        case (w.req_type)
            REQ_EVENT:
            begin
                if (msg_active)
                begin
                    case (msg_phase)
                        PH_START:
                        begin
                            if (w.status_code == ST_START || w.status_code == ST_RSTART)
                            begin
                                r.tx_valid = 1'b1;
                                r.tx_value = msg_slave;
                                if (msg_slave[0])
                                begin
                                    msg_phase = PH_ADDR_R;
                                    msg_pos = 0;
                                end
                                else
                                begin
                                    msg_phase = PH_ADDR_W;
                                    msg_pos = -2;
                                end
                            end
                            else
                                fail = 1'b1;
                            r.clear_start = 1'b1;
                        end
                        PH_ADDR_W:
                        begin
                            if (w.status_code == ST_WADDR_ACK)
                            begin
                                r.tx_valid = 1'b1;
                                r.tx_value = msg_addr_hi;
                                msg_phase = PH_DATA;
                            end
                            else
                                fail = 1'b1;
                        end
                        PH_ADDR_R:
                        begin
                            if (w.status_code == ST_RADDR_ACK)
                            begin
                                msg_phase = PH_RECV;
                                if (msg_len > 1)
                                    r.ack_control = ACK_SET;
                            end
                            else
                                fail = 1'b1;
                        end
                        PH_RECV:
                        begin
                            if (w.status_code == ST_DATA_RX || w.status_code == ST_LAST_RX)
                            begin
                                r.rx_valid = 1'b1;
                                r.rx_data = w.rx_byte;
                                r.rx_position = msg_pos[7:0];
                                msg_pos++;
                                if (msg_pos >= msg_len)
                                    pass = 1'b1;
                                else if (msg_len - msg_pos <= 1)
                                    r.ack_control = ACK_CLEAR;
                            end
                            else
                                fail = 1'b1;
                        end
                        PH_DATA:
                        begin
                            if (w.status_code == ST_DATA_TX)
                            begin
                                msg_pos++;
                                if (msg_pos < 0)
                                begin
                                    r.tx_valid = 1'b1;
                                    r.tx_value = msg_addr_lo;
                                end
                                else if (msg_pos < msg_len)
                                begin
                                    r.tx_valid = 1'b1;
                                    r.tx_value = tx_mem[msg_pos % MAX_LEN];
                                end
                                else
                                    pass = 1'b1;
                            end
                            else
                                fail = 1'b1;
                        end
                        default:
                            msg_phase = PH_START;
                    endcase
                    if (pass || fail)
                    begin
                        r.set_stop = 1'b1;
                        r.ack_control = ACK_CLEAR;
                        r.completion = pass ? CMP_PASS : CMP_FAIL;
                        msg_phase = PH_START;
                        msg_active = 1'b0;
                    end
                end
            end
            REQ_BEGIN:
            begin
                if (msg_active)
                    r.rejected = 1'b1;
                else
                begin
                    msg_slave = w.slave_address;
                    msg_addr_hi = w.mem_addr_high;
                    msg_addr_lo = w.mem_addr_low;
                    msg_len = (w.msg_length > MAX_LEN) ? MAX_LEN : int'(w.msg_length);
                    msg_phase = PH_START;
                    msg_pos = -2;
                    msg_active = 1'b1;
                    r.set_start = 1'b1;
                end
            end
            REQ_LOAD:
                tx_mem[w.load_index] = w.load_byte;
            default:
                ;
        endcase
        r.bus_free = !msg_active;
        return r;
    endfunction

    // Stimulus construction

    function automatic item_t rand_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(item_t)-1:0];
    endfunction

    task automatic add_word(input item_t w, input bit counted);
        pending_words.push_back('{word: w, drain: drain_next});
        drain_next = 1'b0;
        if (counted)
            n_items++;
    endtask

    task automatic send_load(input int idx, input logic [7:0] value);
        item_t w;
        w = rand_item();
        w.req_type = REQ_LOAD;
        w.load_index = idx[7:0];
        w.load_byte = value;
        loaded[idx] = 1'b1;
        add_word(w, 1'b1);
    endtask

    // Make sure every byte a write message will send has been loaded
    task automatic send_begin(input logic [7:0] slave, input logic [7:0] hi,
                              input logic [7:0] lo, input int len);
        item_t w;
        int    lim;
        if (!slave[0])
        begin
            lim = (len > MAX_LEN) ? MAX_LEN : len;
            for (int i = 0; i < lim; i++)
                if (!loaded[i] || $urandom_range(3) == 0)
                    send_load(i, 8'($urandom));
        end
        w = rand_item();
        w.req_type = REQ_BEGIN;
        w.slave_address = slave;
        w.mem_addr_high = hi;
        w.mem_addr_low = lo;
        w.msg_length = len[8:0];
        add_word(w, 1'b1);
    endtask

    task automatic status_step(input logic [2:0] ph, inout int k, input int fail_at,
                               output bit stop);
        item_t      w;
        logic [7:0] good;
        logic [7:0] alt;
        logic [7:0] code;
        if ($urandom_range(99) < noise_pct)
        begin
            w = rand_item();
            case ($urandom_range(2))
                0:
                begin
                    w.req_type = REQ_BEGIN;
                    add_word(w, 1'b1);
                end
                1:
                    send_load($urandom_range(MAX_LEN - 1), 8'($urandom));
                default:
                begin
                    w.req_type = REQ_NONE;
                    add_word(w, 1'b0);
                end
            endcase
        end
        case (ph)
            PH_START:
            begin
                good = ST_START;
                alt = ST_RSTART;
            end
            PH_ADDR_W:
            begin
                good = ST_WADDR_ACK;
                alt = ST_WADDR_ACK;
            end
            PH_ADDR_R:
            begin
                good = ST_RADDR_ACK;
                alt = ST_RADDR_ACK;
            end
            PH_DATA:
            begin
                good = ST_DATA_TX;
                alt = ST_DATA_TX;
            end
            default:
            begin
                good = ST_DATA_RX;
                alt = ST_LAST_RX;
            end
        endcase
        stop = (k == fail_at);
        k++;
        if (stop)
        begin
            do
                code = 8'($urandom_range(255));
            while (code == good || code == alt);
        end
        else
            code = $urandom_range(1) ? good : alt;
        w = rand_item();
        w.req_type = REQ_EVENT;
        w.status_code = code;
        add_word(w, 1'b1);
    endtask

    // Walk one message through its phases; an illegal status at step fail_at ends it
    task automatic run_events(input logic [7:0] slave, input int len, input int fail_at);
        int lsat;
        int k;
        bit stop;
        lsat = (len > MAX_LEN) ? MAX_LEN : len;
        k = 0;
        status_step(PH_START, k, fail_at, stop);
        if (stop)
            return;
        if (!slave[0])
        begin
            status_step(PH_ADDR_W, k, fail_at, stop);
            if (stop)
                return;
            for (int i = 0; i < lsat + 2; i++)
            begin
                status_step(PH_DATA, k, fail_at, stop);
                if (stop)
                    return;
            end
        end
        else
        begin
            status_step(PH_ADDR_R, k, fail_at, stop);
            if (stop)
                return;
            for (int i = 0; i < ((lsat == 0) ? 1 : lsat); i++)
            begin
                status_step(PH_RECV, k, fail_at, stop);
                if (stop)
                    return;
            end
        end
    endtask

    task automatic build_stimulus();
        item_t      w;
        logic [7:0] slave;
        int         len;
        int         lsat;
        int         nsteps;
        int         fail_at;
        bit         mid_drain;
        noise_pct = 0;
        mid_drain = 1'b0;

        // Directed: idle event, unknown request, zero-length write, reject while active,
        // reads of zero and two bytes, failure right after start
        add_word(item_t'('0), 1'b0);
        add_word(item_t'('1), 1'b0);
        send_begin(8'hA0, 8'hFF, 8'h00, 0);
        run_events(8'hA0, 0, -1);
        send_begin(8'h00, 8'h00, 8'hFF, 1);
        w = item_t'('1);
        w.req_type = REQ_BEGIN;
        add_word(w, 1'b1);
        run_events(8'h00, 1, -1);
        send_begin(8'hA1, 8'h00, 8'h00, 0);
        run_events(8'hA1, 0, -1);
        send_begin(8'hFF, 8'hFF, 8'hFF, 2);
        run_events(8'hFF, 2, -1);
        send_begin(8'hA1, 8'h5A, 8'hA5, 3);
        run_events(8'hA1, 3, 0);

        // Random: mostly well-formed messages, some cut short, noise between them
        noise_pct = 5;
        drain_next = 1'b1;
        n_items = 0;
        while (n_items < RANDOM_ITEMS)
        begin
            if (!mid_drain && n_items >= RANDOM_ITEMS / 2)
            begin
                mid_drain = 1'b1;
                drain_next = 1'b1;
            end
            if ($urandom_range(99) < 80)
            begin
                slave = 8'($urandom);
                case ($urandom_range(99)) inside
                    [0:81]:  len = $urandom_range(8);
                    [82:96]: len = $urandom_range(40, 9);
                    default: len = $urandom_range(511, 41);
                endcase
                lsat = (len > MAX_LEN) ? MAX_LEN : len;
                nsteps = slave[0] ? 2 + ((lsat == 0) ? 1 : lsat) : lsat + 4;
                fail_at = ($urandom_range(3) == 0) ? $urandom_range(nsteps - 1) : -1;
                send_begin(slave, 8'($urandom), 8'($urandom), len);
                run_events(slave, len, fail_at);
            end
            else
            begin
                w = rand_item();
                case ($urandom_range(2))
                    0:
                    begin
                        w.req_type = REQ_EVENT;
                        add_word(w, 1'b0);
                    end
                    1:
                    begin
                        w.req_type = REQ_NONE;
                        add_word(w, 1'b0);
                    end
                    default:
                        send_load($urandom_range(MAX_LEN - 1), 8'($urandom));
                endcase
            end
        end
    endtask

    // Sender side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(predict_sequencer_word(offered_word));
                words_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() != 0
                    && !(pending_words[0].drain && expected_results.size() != 0)
                    && $urandom_range(99) >= ((words_sent < n_total / 3) ? 10 :
                                              (words_sent < 2 * n_total / 3) ? 49 : 0))
                begin
                    head_word = pending_words.pop_front();
                    offered_word = head_word.word;
                    s_tdata <= {7'd0, offered_word.load_byte, offered_word.load_index,
                                offered_word.msg_length, offered_word.mem_addr_low,
                                offered_word.mem_addr_high, offered_word.slave_address,
                                offered_word.rx_byte, offered_word.status_code};
                    s_tuser <= offered_word.req_type;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver side and result check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_t got;
                result_t want;
                got.tx_valid    = m_tuser[0];
                got.rx_valid    = m_tuser[1];
                got.tx_value    = m_tdata[7:0];
                got.set_start   = m_tdata[8];
                got.clear_start = m_tdata[9];
                got.set_stop    = m_tdata[10];
                got.ack_control = m_tdata[12:11];
                got.rx_data     = m_tdata[20:13];
                got.rx_position = m_tdata[28:21];
                got.completion  = m_tdata[30:29];
                got.rejected    = m_tdata[31];
                got.bus_free    = m_tdata[32];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %0d: %h", results_taken, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result word %0d differs", results_taken);
                            $display("  expected tx %b/%h start %b clr %b stop %b ack %0d",
                                     want.tx_valid, want.tx_value, want.set_start,
                                     want.clear_start, want.set_stop, want.ack_control);
                            $display("           rx %b/%h@%0d cmp %0d rej %b free %b",
                                     want.rx_valid, want.rx_data, want.rx_position,
                                     want.completion, want.rejected, want.bus_free);
                            $display("  actual   tx %b/%h start %b clr %b stop %b ack %0d",
                                     got.tx_valid, got.tx_value, got.set_start,
                                     got.clear_start, got.set_stop, got.ack_control);
                            $display("           rx %b/%h@%0d cmp %0d rej %b free %b",
                                     got.rx_valid, got.rx_data, got.rx_position,
                                     got.completion, got.rejected, got.bus_free);
                        end
                    end
                end
                results_taken++;
            end
            // Hold off once for a long stretch so the pipeline fills and backs up
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!held && results_taken >= HOLD_AT)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= ((results_taken < n_total / 3) ? 49 :
                                                    (results_taken < 2 * n_total / 3) ? 10 : 0));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        drain_next = 1'b0;
        build_stimulus();
        n_total = pending_words.size();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
